### hw/rtl/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg: shared types and constants
// Formats, register codes and the arctangent table for the ERP projector.
// ----------------------------------------------------------------------------
package sve_pkg;

	localparam int COMPONENT_BITS_DEF      = 18;
	localparam int ANGLE_FRACTION_BITS_DEF = 20;

	// Normalized components lie in (-2^31, 2^31).
	localparam int NORM_W       = 33;
	localparam int MAG_W        = 32;
	localparam int SQ_W         = 64;
	localparam int ROOT_STEPS   = 32;
	localparam int NORM_STAGES  = 5;
	localparam int CORDIC_W     = 36;
	localparam int CORDIC_STEPS = 32;
	localparam int ANGLE_W      = 32;

	localparam int WIDTH_W  = 15;
	localparam int HEIGHT_W = 14;
	localparam int COL_W    = 14;
	localparam int ROW_W    = 13;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 15'd3840;
	localparam logic [WIDTH_W-1:0]  MAX_WIDTH    = 15'd16384;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 14'd1920;
	localparam logic [HEIGHT_W-1:0] MAX_HEIGHT   = 14'd8192;
	localparam logic [ANGLE_W-1:0]  HALF_TURN    = 32'h8000_0000;

	// Register index as decoded from paddr[2].
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic signed [NORM_W-1:0] x;
		logic signed [NORM_W-1:0] y;
		logic signed [NORM_W-1:0] z;
		logic                     zero;
	} vec_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] a_az;
		logic signed [CORDIC_W-1:0] b_az;
		logic [ANGLE_W-1:0]         ang_az;
		logic signed [CORDIC_W-1:0] a_el;
		logic signed [CORDIC_W-1:0] b_el;
		logic [ANGLE_W-1:0]         ang_el;
		logic                       zero;
		logic                       az_zero;
	} rot_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             invalid;
	} pix_t;

	// atan(2^-i) in turns, 32 fractional bits, rounded to nearest.
	function automatic logic [ANGLE_W-1:0] atan_turns(input logic [4:0] idx);
		logic [ANGLE_W-1:0] r;
		unique case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			5'd31: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/sphere_vector_to_erp_pixel.sv
// ----------------------------------------------------------------------------
// sphere_vector_to_erp_pixel: direction vector to equirectangular pixel
// Maps a 3D direction onto the column and row of an ERP frame.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel as x, y, z components and leave on the
// m_axis channel as pixel column and row, with an invalid flag in tuser for
// the zero vector. The frame size is set over the APB port at byte offsets
// 0 (width) and 4 (height); write it only while no items are in flight.
// The datapath is a row of cells: five normalization shifts, squaring and
// summing stages, 32 square-root digit cells, a pre-rotation, 32 CORDIC
// cells that resolve azimuth and elevation together, and three scaling
// stages. One item enters every clock while the output queue has room.
// A two-entry output queue sits between the cells and m_axis, so the input
// stays ready while one result waits. When both entries are full the whole
// row of cells holds and s_axis_tready drops until m_axis_tready returns.
// Reset empties the pipeline and the queue and loads the frame size with
// 3840 by 1920; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sphere_vector_to_erp_pixel #(
	parameter int COMPONENT_BITS      = sve_pkg::COMPONENT_BITS_DEF,
	parameter int ANGLE_FRACTION_BITS = sve_pkg::ANGLE_FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// x_component, y_component, z_component, zero padding
	input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pixel_column, pixel_row, zero padding
	output logic [31:0]                           m_axis_tdata,
	// invalid_vector
	output logic                                  m_axis_tuser,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sve_pkg::ADDR_W-1:0]            paddr,
	input  logic [sve_pkg::DATA_W-1:0]            pwdata,
	output logic [sve_pkg::DATA_W-1:0]            prdata,
	output logic                                  pready
);
	import sve_pkg::*;

	localparam int CB = COMPONENT_BITS;

	logic en;

	// Configuration registers.
	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[HEIGHT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
		endcase
	end

	// Input stage: sign extension and the OR of the magnitudes, which has its
	// leading one where the largest magnitude has it.
	logic signed [NORM_W-1:0] xi, yi, zi, ax, ay, az;
	logic                     valid_s1;
	vec_t                     vec_s1;
	logic [MAG_W-1:0]         mag_s1;

	always_comb begin
		xi = NORM_W'($signed(s_axis_tdata[CB-1:0]));
		yi = NORM_W'($signed(s_axis_tdata[2*CB-1:CB]));
		zi = NORM_W'($signed(s_axis_tdata[3*CB-1:2*CB]));
		ax = xi[NORM_W-1] ? -xi : xi;
		ay = yi[NORM_W-1] ? -yi : yi;
		az = zi[NORM_W-1] ? -zi : zi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1.x    <= xi;
			vec_s1.y    <= yi;
			vec_s1.z    <= zi;
			vec_s1.zero <= (xi == '0) && (yi == '0) && (zi == '0);
			mag_s1      <= ax[MAG_W-1:0] | ay[MAG_W-1:0] | az[MAG_W-1:0];
		end
	end

	// Normalization cells: shifts of 16, 8, 4, 2 and 1.
	vec_t             nvec [0:NORM_STAGES];
	logic [MAG_W-1:0] nmag [0:NORM_STAGES];
	logic             nvld [0:NORM_STAGES];

	assign nvec[0] = vec_s1;
	assign nmag[0] = mag_s1;
	assign nvld[0] = valid_s1;

	for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
		sve_norm_cell #(.SHIFT(16 >> k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (nvld[k]),
			.vec_in   (nvec[k]),
			.mag_in   (nmag[k]),
			.valid_q  (nvld[k+1]),
			.vec_q    (nvec[k+1]),
			.mag_q    (nmag[k+1])
		);
	end

	// Squares of x and z, then their sum.
	vec_t                     nv;
	logic signed [NORM_W-1:0] nax, naz;
	logic [SQ_W-1:0]          sqx_s2, sqz_s2, sum_s3;
	vec_t                     vec_s2, vec_s3;
	logic                     valid_s2, valid_s3;

	assign nv  = nvec[NORM_STAGES];
	assign nax = nv.x[NORM_W-1] ? -nv.x : nv.x;
	assign naz = nv.z[NORM_W-1] ? -nv.z : nv.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= nvld[NORM_STAGES];
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= SQ_W'(nax[MAG_W-1:0]) * SQ_W'(nax[MAG_W-1:0]);
			sqz_s2 <= SQ_W'(naz[MAG_W-1:0]) * SQ_W'(naz[MAG_W-1:0]);
			vec_s2 <= nv;
			sum_s3 <= sqx_s2 + sqz_s2;
			vec_s3 <= vec_s2;
		end
	end

	// Square-root digit cells.
	logic [SQ_W-1:0] rrem [0:ROOT_STEPS];
	logic [SQ_W-1:0] rres [0:ROOT_STEPS];
	vec_t            rvec [0:ROOT_STEPS];
	logic            rvld [0:ROOT_STEPS];

	assign rrem[0] = sum_s3;
	assign rres[0] = '0;
	assign rvec[0] = vec_s3;
	assign rvld[0] = valid_s3;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		sve_isqrt_cell #(.STEP(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (rvld[k]),
			.rem_in   (rrem[k]),
			.res_in   (rres[k]),
			.vec_in   (rvec[k]),
			.valid_q  (rvld[k+1]),
			.rem_q    (rrem[k+1]),
			.res_q    (rres[k+1]),
			.vec_q    (rvec[k+1])
		);
	end

	// Pre-rotation: a vector in the left half plane is turned by a half turn.
	vec_t                       rv;
	logic signed [CORDIC_W-1:0] cx, cy, cz, cr;
	rot_t                       rot_pre;
	logic                       valid_s4;
	rot_t                       rot_s4;

	always_comb begin
		rv = rvec[ROOT_STEPS];
		cx = CORDIC_W'(rv.x);
		cy = CORDIC_W'(rv.y);
		cz = CORDIC_W'(rv.z);
		cr = CORDIC_W'(rres[ROOT_STEPS][MAG_W-1:0]);
		if (cx < 0) begin
			rot_pre.a_az   = -cx;
			rot_pre.b_az   = cz;
			rot_pre.ang_az = HALF_TURN;
		end else begin
			rot_pre.a_az   = cx;
			rot_pre.b_az   = -cz;
			rot_pre.ang_az = '0;
		end
		rot_pre.a_el    = cr;
		rot_pre.b_el    = cy;
		rot_pre.ang_el  = '0;
		rot_pre.zero    = rv.zero;
		rot_pre.az_zero = (rv.x == '0) && (rv.z == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= rvld[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s4 <= rot_pre;
		end
	end

	// CORDIC cells.
	rot_t crot [0:CORDIC_STEPS];
	logic cvld [0:CORDIC_STEPS];

	assign crot[0] = rot_s4;
	assign cvld[0] = valid_s4;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		sve_cordic_cell #(.STEP(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (cvld[k]),
			.rot_in   (crot[k]),
			.valid_q  (cvld[k+1]),
			.rot_q    (crot[k+1])
		);
	end

	// Scaling to pixel indices.
	logic map_valid;
	pix_t map_pix;

	sve_pixel_map #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid_in     (cvld[CORDIC_STEPS]),
		.ang_az       (crot[CORDIC_STEPS].ang_az),
		.ang_el       (crot[CORDIC_STEPS].ang_el),
		.zero         (crot[CORDIC_STEPS].zero),
		.az_zero      (crot[CORDIC_STEPS].az_zero),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.valid_q      (map_valid),
		.pix_q        (map_pix)
	);

	// Two-entry output queue. The cells advance whenever it has room.
	pix_t       oq_q [0:1];
	logic [1:0] cnt_q;
	logic       wr_ptr_q, rd_ptr_q;
	logic       push, pop;
	pix_t       head;

	assign en            = (cnt_q != 2'd2);
	assign s_axis_tready = en;
	assign push          = en && map_valid;
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign head          = oq_q[rd_ptr_q];
	assign m_axis_tdata  = {5'b0, head.row, head.col};
	assign m_axis_tuser  = head.invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_q[wr_ptr_q] <= map_pix;
		end
	end

endmodule

### hw/rtl/sve_norm_cell.sv
// ----------------------------------------------------------------------------
// sve_norm_cell: one normalization step
// Shifts all three components left by SHIFT when the largest magnitude allows.
// ----------------------------------------------------------------------------
module sve_norm_cell #(
	parameter int SHIFT = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_in,
	input  sve_pkg::vec_t               vec_in,
	input  logic [sve_pkg::MAG_W-1:0]   mag_in,
	output logic                        valid_q,
	output sve_pkg::vec_t               vec_q,
	output logic [sve_pkg::MAG_W-1:0]   mag_q
);
	import sve_pkg::*;

	logic go;

	// The shift is taken while the magnitude stays below 2^31 afterwards.
	assign go = (mag_in >> (MAG_W - 1 - SHIFT)) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q.zero <= vec_in.zero;
			if (go) begin
				vec_q.x <= vec_in.x <<< SHIFT;
				vec_q.y <= vec_in.y <<< SHIFT;
				vec_q.z <= vec_in.z <<< SHIFT;
				mag_q   <= mag_in << SHIFT;
			end else begin
				vec_q.x <= vec_in.x;
				vec_q.y <= vec_in.y;
				vec_q.z <= vec_in.z;
				mag_q   <= mag_in;
			end
		end
	end

endmodule

### hw/rtl/sve_isqrt_cell.sv
// ----------------------------------------------------------------------------
// sve_isqrt_cell: one digit of the integer square root
// Decides one result bit and carries the component vector alongside.
// ----------------------------------------------------------------------------
module sve_isqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_in,
	input  logic [sve_pkg::SQ_W-1:0]   rem_in,
	input  logic [sve_pkg::SQ_W-1:0]   res_in,
	input  sve_pkg::vec_t              vec_in,
	output logic                       valid_q,
	output logic [sve_pkg::SQ_W-1:0]   rem_q,
	output logic [sve_pkg::SQ_W-1:0]   res_q,
	output sve_pkg::vec_t              vec_q
);
	import sve_pkg::*;

	localparam logic [SQ_W-1:0] BIT = 64'd1 << (SQ_W - 2 - 2 * STEP);

	logic [SQ_W-1:0] trial;

	assign trial = res_in + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= vec_in;
			if (rem_in >= trial) begin
				rem_q <= rem_in - trial;
				res_q <= (res_in >> 1) + BIT;
			end else begin
				rem_q <= rem_in;
				res_q <= res_in >> 1;
			end
		end
	end

endmodule

### hw/rtl/sve_cordic_cell.sv
// ----------------------------------------------------------------------------
// sve_cordic_cell: one CORDIC vectoring iteration
// Rotates the azimuth and the elevation vector by one table angle each.
// ----------------------------------------------------------------------------
module sve_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  sve_pkg::rot_t rot_in,
	output logic          valid_q,
	output sve_pkg::rot_t rot_q
);
	import sve_pkg::*;

	localparam logic [ANGLE_W-1:0] ATAN = atan_turns(5'(STEP));

	logic signed [CORDIC_W-1:0] a_az, b_az, a_el, b_el;
	rot_t nxt;

	always_comb begin
		a_az = rot_in.a_az;
		b_az = rot_in.b_az;
		a_el = rot_in.a_el;
		b_el = rot_in.b_el;
		nxt  = rot_in;
		if (b_az > 0) begin
			nxt.a_az   = a_az + (b_az >>> STEP);
			nxt.b_az   = b_az - (a_az >>> STEP);
			nxt.ang_az = rot_in.ang_az + ATAN;
		end else begin
			nxt.a_az   = a_az - (b_az >>> STEP);
			nxt.b_az   = b_az + (a_az >>> STEP);
			nxt.ang_az = rot_in.ang_az - ATAN;
		end
		if (b_el > 0) begin
			nxt.a_el   = a_el + (b_el >>> STEP);
			nxt.b_el   = b_el - (a_el >>> STEP);
			nxt.ang_el = rot_in.ang_el + ATAN;
		end else begin
			nxt.a_el   = a_el - (b_el >>> STEP);
			nxt.b_el   = b_el + (a_el >>> STEP);
			nxt.ang_el = rot_in.ang_el - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q <= nxt;
		end
	end

endmodule

### hw/rtl/sve_pixel_map.sv
// ----------------------------------------------------------------------------
// sve_pixel_map: angle to pixel index
// Rounds both angles, scales them by the frame size and wraps the indices.
// ----------------------------------------------------------------------------
module sve_pixel_map #(
	parameter int ANGLE_FRACTION_BITS = sve_pkg::ANGLE_FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           valid_in,
	input  logic [sve_pkg::ANGLE_W-1:0]    ang_az,
	input  logic [sve_pkg::ANGLE_W-1:0]    ang_el,
	input  logic                           zero,
	input  logic                           az_zero,
	input  logic [sve_pkg::WIDTH_W-1:0]    frame_width,
	input  logic [sve_pkg::HEIGHT_W-1:0]   frame_height,
	output logic                           valid_q,
	output sve_pkg::pix_t                  pix_q
);
	import sve_pkg::*;

	localparam int F  = ANGLE_FRACTION_BITS;
	localparam int SD = ANGLE_W - F;
	localparam int VW = F + 3;
	localparam logic [ANGLE_W:0] HALF_RND = (33'd1 << SD) >> 1;
	localparam logic signed [VW-1:0] ONE_V  = VW'(1) << F;
	localparam logic signed [VW-1:0] HALF_V = VW'(1) << (F - 1);

	logic [ANGLE_W-1:0]       az_eff, u32;
	logic [ANGLE_W:0]         u_sum, el_sum;
	logic signed [F:0]        el_f;
	logic signed [VW-1:0]     vf;
	logic [F:0]               vf_clamp;
	logic [WIDTH_W-1:0]       w_eff;
	logic [HEIGHT_W-1:0]      h_eff;

	logic                     valid_s1, valid_s2;
	logic                     zero_s1, zero_s2;
	logic [F:0]               uf_s1, vf_s1;
	logic [WIDTH_W-1:0]       w_s1, w_s2;
	logic [HEIGHT_W-1:0]      h_s1, h_s2;
	logic [F+WIDTH_W:0]       pu_s2;
	logic [F+HEIGHT_W:0]      pv_s2;

	logic [WIDTH_W:0]         m_full;
	logic [HEIGHT_W:0]        n_full;

	always_comb begin
		az_eff = az_zero ? '0 : ang_az;
		u32    = az_eff + HALF_TURN;
		u_sum  = {1'b0, u32} + HALF_RND;
		el_sum = {ang_el[ANGLE_W-1], ang_el} + HALF_RND;
		el_f   = el_sum[ANGLE_W:SD];
		vf     = HALF_V - ({{2{el_f[F]}}, el_f} <<< 1);
		if (vf[VW-1]) begin
			vf_clamp = '0;
		end else if (vf > ONE_V) begin
			vf_clamp = ONE_V[F:0];
		end else begin
			vf_clamp = vf[F:0];
		end
		w_eff = (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
		h_eff = (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
	end

	assign m_full = pu_s2[F+WIDTH_W:F];
	assign n_full = pv_s2[F+HEIGHT_W:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uf_s1   <= u_sum[ANGLE_W:SD];
			vf_s1   <= vf_clamp;
			w_s1    <= w_eff;
			h_s1    <= h_eff;
			zero_s1 <= zero;

			pu_s2   <= (F+WIDTH_W+1)'(uf_s1) * (F+WIDTH_W+1)'(w_s1);
			pv_s2   <= (F+HEIGHT_W+1)'(vf_s1) * (F+HEIGHT_W+1)'(h_s1);
			w_s2    <= w_s1;
			h_s2    <= h_s1;
			zero_s2 <= zero_s1;

			pix_q.invalid <= zero_s2;
			// An index at or above the frame size wraps to zero.
			if (zero_s2 || m_full >= {1'b0, w_s2}) begin
				pix_q.col <= '0;
			end else begin
				pix_q.col <= m_full[COL_W-1:0];
			end
			if (zero_s2 || n_full >= {1'b0, h_s2}) begin
				pix_q.row <= '0;
			end else begin
				pix_q.row <= n_full[ROW_W-1:0];
			end
		end
	end

endmodule
